>>> rtl/dsjq_pkg.sv
`timescale 1ns / 1ps

package dsjq_pkg;

  // default sizing, taken by the top level as its parameter defaults
  localparam int unsigned DEPTH_DEF        = 64;
  localparam int unsigned HANDLE_COUNT_DEF = 256;

  // operation codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_REMOVE = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // one held job entry
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] task_id;
    logic [7:0]  handle;
  } entry_t;

  // input beat
  typedef struct packed {
    op_e         op;
    logic [31:0] key;
    logic [31:0] task_id;
    logic [7:0]  job_handle;
  } in_t;

  // result beat
  typedef struct packed {
    status_e     status;
    logic [7:0]  head_handle;
    logic [31:0] head_key;
    logic [31:0] head_task;
    logic [6:0]  removed_count;
    logic [6:0]  occupancy;
  } out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    latch;
    logic    ins_init;
    logic    ins_step;
    logic    ins_last;
    logic    scan_init;
    logic    scan_step;
    logic    finish;
    status_e status;
  } ctrl_t;

  // status from the datapath to the controller
  typedef struct packed {
    op_e  op;
    logic count_zero;
    logic count_full;
    logic key_lt;
    logic p_one;
    logic scan_done;
  } stat_t;

endpackage

>>> rtl/dsjq_dp.sv
`timescale 1ns / 1ps

module dsjq_dp #(
  parameter int unsigned DEPTH        = dsjq_pkg::DEPTH_DEF,
  parameter int unsigned HANDLE_COUNT = dsjq_pkg::HANDLE_COUNT_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dsjq_pkg::in_t   cmd_i,
  input  dsjq_pkg::ctrl_t ctrl_i,
  output dsjq_pkg::stat_t stat_o,
  output dsjq_pkg::out_t  result_o,
  output logic            result_valid_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // entry store
  dsjq_pkg::entry_t mem_q [DEPTH];
  dsjq_pkg::entry_t rd_q;
  dsjq_pkg::entry_t wd;
  logic             we;
  logic [AW-1:0]    wa;
  logic [AW-1:0]    ra;

  // control and walk state
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    p_q, p_d;
  logic [CW-1:0]    rp_q, rp_d;
  logic [CW-1:0]    wp_q, wp_d;
  logic [CW-1:0]    rd_idx_q, rd_idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic             valid_q, valid_d;

  // latched operation
  dsjq_pkg::op_e    op_q;
  logic [31:0]      key_q;
  logic [31:0]      task_q;
  logic [7:0]       handle_q;
  dsjq_pkg::entry_t head_q, head_d;
  dsjq_pkg::out_t   result_q, result_d;

  dsjq_pkg::entry_t new_entry;
  logic [CW-1:0]    cnt_m1;
  logic [CW-1:0]    p_m2;
  logic             issue;
  logic             keep;
  logic             ok;
  logic             head_op;

  // handle reduction table, worked out at elaboration
  logic [7:0] handle_tbl [256];
  for (genvar g = 0; g < 256; g++) begin : g_handle
    assign handle_tbl[g] = 8'(g % HANDLE_COUNT);
  end

  assign new_entry = '{key: key_q, task_id: task_q, handle: handle_q};
  assign cnt_m1    = count_q - CW'(1);
  assign p_m2      = p_q - CW'(2);
  assign issue     = ctrl_i.scan_step && (rp_q < count_q);
  assign head_op   = (op_q == dsjq_pkg::OP_POP) || (op_q == dsjq_pkg::OP_PEEK);
  assign ok        = (ctrl_i.status == dsjq_pkg::ST_OK);

  // keep test for the compaction scan
  always_comb begin
    case (op_q)
      dsjq_pkg::OP_POP:    keep = (rd_idx_q != '0);
      dsjq_pkg::OP_REMOVE: keep = (rd_q.task_id != task_q);
      default:             keep = 1'b0;
    endcase
  end

  // status back to the controller
  assign stat_o.op         = op_q;
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.count_full = (count_q == CW'(DEPTH));
  assign stat_o.key_lt     = (key_q < rd_q.key);
  assign stat_o.p_one      = (p_q == CW'(1));
  assign stat_o.scan_done  = (rp_q == count_q) && !rd_vld_q;

  // walk and finish logic
  always_comb begin
    we       = 1'b0;
    wa       = '0;
    wd       = new_entry;
    ra       = '0;
    p_d      = p_q;
    rp_d     = rp_q;
    wp_d     = wp_q;
    rd_idx_d = rd_idx_q;
    rd_vld_d = 1'b0;
    head_d   = head_q;
    count_d  = count_q;
    valid_d  = 1'b0;
    result_d = result_q;

    // insert: start the downward walk at the tail
    if (ctrl_i.ins_init) begin
      p_d = count_q;
      if (count_q != '0) begin
        ra = cnt_m1[AW-1:0];
      end
    end

    // insert: move one larger entry up or drop the new one in
    if (ctrl_i.ins_step) begin
      we = 1'b1;
      wa = p_q[AW-1:0];
      if (stat_o.key_lt) begin
        wd  = rd_q;
        p_d = p_q - CW'(1);
        if (p_q >= CW'(2)) begin
          ra = p_m2[AW-1:0];
        end
      end
    end

    // insert at the slot the walk ended on
    if (ctrl_i.ins_last) begin
      we = 1'b1;
      wa = p_q[AW-1:0];
    end

    // compaction scan for pop, peek and remove
    if (ctrl_i.scan_init) begin
      rp_d   = '0;
      wp_d   = '0;
      head_d = '0;
    end

    if (ctrl_i.scan_step) begin
      rd_vld_d = issue;
      if (issue) begin
        ra       = rp_q[AW-1:0];
        rp_d     = rp_q + CW'(1);
        rd_idx_d = rp_q;
      end
      if (rd_vld_q) begin
        if (keep) begin
          we   = 1'b1;
          wa   = wp_q[AW-1:0];
          wd   = rd_q;
          wp_d = wp_q + CW'(1);
        end
        if ((rd_idx_q == '0) && head_op) begin
          head_d = rd_q;
        end
      end
    end

    // result beat and new occupancy
    if (ctrl_i.finish) begin
      valid_d = 1'b1;
      if (ok) begin
        case (op_q)
          dsjq_pkg::OP_INSERT: count_d = count_q + CW'(1);
          dsjq_pkg::OP_POP:    count_d = wp_q;
          dsjq_pkg::OP_REMOVE: count_d = wp_q;
          default:             count_d = count_q;
        endcase
      end
      result_d.status = ctrl_i.status;
      if (ok && head_op) begin
        result_d.head_handle = head_q.handle;
        result_d.head_key    = head_q.key;
        result_d.head_task   = head_q.task_id;
      end else begin
        result_d.head_handle = '0;
        result_d.head_key    = '0;
        result_d.head_task   = '0;
      end
      if (op_q == dsjq_pkg::OP_REMOVE) begin
        result_d.removed_count = 7'(count_q - wp_q);
      end else begin
        result_d.removed_count = '0;
      end
      result_d.occupancy = 7'(count_d);
    end
  end

  // entry store, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_vld_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
      valid_q  <= valid_d;
    end
  end

  // payload and pointer registers
  always_ff @(posedge clk_i) begin
    p_q      <= p_d;
    rp_q     <= rp_d;
    wp_q     <= wp_d;
    rd_idx_q <= rd_idx_d;
    head_q   <= head_d;
    result_q <= result_d;
    if (ctrl_i.latch) begin
      op_q     <= cmd_i.op;
      key_q    <= cmd_i.key;
      task_q   <= cmd_i.task_id;
      handle_q <= handle_tbl[cmd_i.job_handle];
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

>>> rtl/dsjq_ctrl.sv
`timescale 1ns / 1ps

module dsjq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  dsjq_pkg::stat_t stat_i,
  output dsjq_pkg::ctrl_t ctrl_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DECODE   = 6'b000010,
    S_SCAN     = 6'b000100,
    S_INS_WALK = 6'b001000,
    S_INS_LAST = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  dsjq_pkg::status_e st_q, st_d;

  assign busy = (state_q != S_IDLE);

  // sequencer
  always_comb begin
    state_d          = state_q;
    st_d             = st_q;
    ctrl_o           = '0;
    ctrl_o.status    = st_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.latch = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        st_d = dsjq_pkg::ST_OK;
        case (stat_i.op)
          dsjq_pkg::OP_INSERT: begin
            if (stat_i.count_full) begin
              st_d    = dsjq_pkg::ST_FULL;
              state_d = S_DONE;
            end else begin
              ctrl_o.ins_init = 1'b1;
              state_d         = stat_i.count_zero ? S_INS_LAST : S_INS_WALK;
            end
          end
          dsjq_pkg::OP_POP, dsjq_pkg::OP_PEEK: begin
            if (stat_i.count_zero) begin
              st_d    = dsjq_pkg::ST_EMPTY;
              state_d = S_DONE;
            end else begin
              ctrl_o.scan_init = 1'b1;
              state_d          = S_SCAN;
            end
          end
          dsjq_pkg::OP_REMOVE: begin
            ctrl_o.scan_init = 1'b1;
            state_d          = S_SCAN;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        ctrl_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_DONE;
        end
      end
      S_INS_WALK: begin
        ctrl_o.ins_step = 1'b1;
        if (!stat_i.key_lt) begin
          state_d = S_DONE;
        end else if (stat_i.p_one) begin
          state_d = S_INS_LAST;
        end
      end
      S_INS_LAST: begin
        ctrl_o.ins_last = 1'b1;
        state_d         = S_DONE;
      end
      S_DONE: begin
        ctrl_o.finish = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      st_q    <= dsjq_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  // an accepted beat always goes to decode
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> state_q == S_DECODE)
    else $error("accepted beat did not reach decode");

  // exactly one finish per operation
  a_finish_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.finish |=> !ctrl_o.finish && !busy)
    else $error("finish not followed by idle");

  // the insert walk never runs on a full queue
  a_walk_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS_WALK |-> !stat_i.count_full)
    else $error("insert walk on full queue");

  // full status only belongs to insert
  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.finish && (st_q == dsjq_pkg::ST_FULL) |-> stat_i.op == dsjq_pkg::OP_INSERT)
    else $error("full status on non-insert");

endmodule

>>> rtl/deadline_sorted_job_queue.sv
// sequencing: full insert and empty pop/peek go from decode straight to the done state and
//   the result strobe; others grow with N, the entries held, set by the one-entry-per-cycle
//   walk over the single-port-read entry store (insert walks only the larger entries)
// throughput: one operation at a time, busy is high from accept until the result cycle
// reset: asynchronous active low, empties the queue; entry store keeps no reset
// results are shown for one cycle on result_valid_o and cannot be stalled
`timescale 1ns / 1ps

module deadline_sorted_job_queue #(
  parameter int unsigned DEPTH        = dsjq_pkg::DEPTH_DEF,
  parameter int unsigned HANDLE_COUNT = dsjq_pkg::HANDLE_COUNT_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  dsjq_pkg::in_t  cmd_i,
  output logic           result_valid_o,
  output dsjq_pkg::out_t result_o
);

  dsjq_pkg::ctrl_t ctrl;
  dsjq_pkg::stat_t stat;

  // sequencer
  dsjq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // entry store and walk datapath
  dsjq_dp #(
    .DEPTH        (DEPTH),
    .HANDLE_COUNT (HANDLE_COUNT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

>>> bench/deadline_sorted_job_queue_tb.sv
`timescale 1ns / 1ps

module deadline_sorted_job_queue_tb;

  localparam int unsigned QDEPTH      = dsjq_pkg::DEPTH_DEF;
  localparam int unsigned HANDLES     = dsjq_pkg::HANDLE_COUNT_DEF;
  localparam int          ITEM_TARGET = 1550;
  localparam int          STALL_LIMIT = 2000;
  localparam int          N_ROWS      = 21;

  // mix of operations within one random phase
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_MIXED, MIX_PURGE} mix_e;

  typedef struct {
    dsjq_pkg::in_t  cmd;
    bit             typed;
    dsjq_pkg::out_t want;
  } row_t;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  dsjq_pkg::in_t  cmd_i;
  logic           result_valid_o;
  dsjq_pkg::out_t result_o;

  deadline_sorted_job_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // shadow of the queue and the results still owed by the block
  dsjq_pkg::entry_t held_jobs[$];
  dsjq_pkg::out_t   owed_results[$];

  int errors;
  int items_sent;
  int idle_run;
  int n_insert, n_pop, n_peek, n_remove, n_full, n_empty, n_purged, peak_fill;

  localparam logic [31:0] TASK_POOL [8] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
    32'hFFFF_FFFF, 32'h8000_0000, 32'h5A5A_5A5A, 32'hA5A5_A5A5
  };

  // directed beats; typed-in results only where they are obvious
  row_t directed_rows [N_ROWS] = '{
    '{'{dsjq_pkg::OP_POP,    32'hDEAD_BEEF, 32'h0000_0000, 8'hA5}, 1'b1,
      '{dsjq_pkg::ST_EMPTY, 8'h00, 32'h0, 32'h0, 7'd0, 7'd0}},
    '{'{dsjq_pkg::OP_PEEK,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 1'b1,
      '{dsjq_pkg::ST_EMPTY, 8'h00, 32'h0, 32'h0, 7'd0, 7'd0}},
    '{'{dsjq_pkg::OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 8'h00}, 1'b1,
      '{dsjq_pkg::ST_OK, 8'h00, 32'h0, 32'h0, 7'd0, 7'd0}},
    '{'{dsjq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 1'b1,
      '{dsjq_pkg::ST_OK, 8'h00, 32'h0, 32'h0, 7'd0, 7'd1}},
    '{'{dsjq_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000, 8'h00}, 1'b1,
      '{dsjq_pkg::ST_OK, 8'h00, 32'h0, 32'h0, 7'd0, 7'd2}},
    '{'{dsjq_pkg::OP_PEEK,   32'h1234_5678, 32'h0BAD_F00D, 8'h5A}, 1'b1,
      '{dsjq_pkg::ST_OK, 8'h00, 32'h0, 32'h0, 7'd0, 7'd2}},
    '{'{dsjq_pkg::OP_INSERT, 32'h0000_1000, 32'h0000_0005, 8'h11}, 1'b0, '0},
    '{'{dsjq_pkg::OP_INSERT, 32'h0000_1000, 32'h0000_0006, 8'h22}, 1'b0, '0},
    '{'{dsjq_pkg::OP_INSERT, 32'h0000_1000, 32'h0000_0005, 8'h33}, 1'b0, '0},
    '{'{dsjq_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0007, 8'h44}, 1'b0, '0},
    '{'{dsjq_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0005, 8'h55}, 1'b0, '0},
    '{'{dsjq_pkg::OP_POP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF}, 1'b0, '0},
    '{'{dsjq_pkg::OP_PEEK,   32'h0000_0000, 32'h0000_0000, 8'h00}, 1'b0, '0},
    '{'{dsjq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 32'h0000_0005, 8'hFF}, 1'b0, '0},
    '{'{dsjq_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0005, 8'h00}, 1'b0, '0},
    '{'{dsjq_pkg::OP_REMOVE, 32'h0000_0000, 32'h1234_5678, 8'h00}, 1'b0, '0},
    '{'{dsjq_pkg::OP_POP,    32'h0000_0000, 32'h0000_0000, 8'h00}, 1'b0, '0},
    '{'{dsjq_pkg::OP_POP,    32'h0000_0000, 32'h0000_0000, 8'h00}, 1'b0, '0},
    '{'{dsjq_pkg::OP_POP,    32'h0000_0000, 32'h0000_0000, 8'h00}, 1'b0, '0},
    '{'{dsjq_pkg::OP_POP,    32'h0000_0000, 32'h0000_0000, 8'h00}, 1'b1,
      '{dsjq_pkg::ST_EMPTY, 8'h00, 32'h0, 32'h0, 7'd0, 7'd0}},
    '{'{dsjq_pkg::OP_PEEK,   32'h0000_0000, 32'h0000_0000, 8'h00}, 1'b1,
      '{dsjq_pkg::ST_EMPTY, 8'h00, 32'h0, 32'h0, 7'd0, 7'd0}}
  };

  // applies one command to the shadow queue and gives the result it owes
  function automatic dsjq_pkg::out_t apply_job_op(dsjq_pkg::in_t c);
    dsjq_pkg::out_t   r;
    dsjq_pkg::entry_t e;
    dsjq_pkg::entry_t kept[$];
    int               pos;
    r = '0;
    r.status = dsjq_pkg::ST_OK;
    case (c.op)
      dsjq_pkg::OP_INSERT: begin
        n_insert++;
        if (held_jobs.size() >= QDEPTH) begin
          r.status = dsjq_pkg::ST_FULL;
          n_full++;
        end else begin
          // after every equal or smaller key, so ties leave in arrival order
          pos = 0;
          while (pos < held_jobs.size() && !(c.key < held_jobs[pos].key)) pos++;
          e.key     = c.key;
          e.task_id = c.task_id;
          e.handle  = 8'(c.job_handle % HANDLES);
          held_jobs.insert(pos, e);
        end
      end
      dsjq_pkg::OP_POP, dsjq_pkg::OP_PEEK: begin
        if (c.op == dsjq_pkg::OP_POP) n_pop++;
        else n_peek++;
        if (held_jobs.size() == 0) begin
          r.status = dsjq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          r.head_handle = held_jobs[0].handle;
          r.head_key    = held_jobs[0].key;
          r.head_task   = held_jobs[0].task_id;
          if (c.op == dsjq_pkg::OP_POP) void'(held_jobs.pop_front());
        end
      end
      default: begin
        n_remove++;
        foreach (held_jobs[i])
          if (held_jobs[i].task_id != c.task_id) kept.push_back(held_jobs[i]);
        r.removed_count = 7'(held_jobs.size() - kept.size());
        n_purged += held_jobs.size() - kept.size();
        held_jobs = kept;
      end
    endcase
    r.occupancy = 7'(held_jobs.size());
    if (held_jobs.size() > peak_fill) peak_fill = held_jobs.size();
    return r;
  endfunction

  // one random command, weighted by the phase mix
  function automatic dsjq_pkg::in_t random_job_cmd(mix_e mix);
    dsjq_pkg::in_t c;
    int            r;
    int            w_ins, w_pop, w_peek;
    case (mix)
      MIX_FILL:  begin w_ins = 80; w_pop = 8;  w_peek = 6;  end
      MIX_DRAIN: begin w_ins = 15; w_pop = 60; w_peek = 15; end
      MIX_PURGE: begin w_ins = 45; w_pop = 10; w_peek = 10; end
      default:   begin w_ins = 40; w_pop = 25; w_peek = 20; end
    endcase
    r = $urandom_range(99);
    if (r < w_ins) c.op = dsjq_pkg::OP_INSERT;
    else if (r < w_ins + w_pop) c.op = dsjq_pkg::OP_POP;
    else if (r < w_ins + w_pop + w_peek) c.op = dsjq_pkg::OP_PEEK;
    else c.op = dsjq_pkg::OP_REMOVE;
    // keys: a narrow band for ties, some extremes, the rest anywhere
    r = $urandom_range(9);
    if (r == 0) c.key = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    else if (r < 5) c.key = 32'($urandom_range(15));
    else c.key = $urandom;
    // task ids from a small pool so removes find matches
    if ($urandom_range(9) < 7) c.task_id = TASK_POOL[$urandom_range(7)];
    else c.task_id = $urandom;
    c.job_handle = 8'($urandom_range(255));
    return c;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("  %s: got %0h want %0h at %0t ns", what, got, want, $time);
    errors++;
  endtask

  // present one beat and wait for it to be taken
  task automatic issue_cmd(dsjq_pkg::in_t c, bit typed, dsjq_pkg::out_t want,
                           bit may_idle);
    dsjq_pkg::out_t predicted;
    @(negedge clk_i);
    if (may_idle)
      while ($urandom_range(99) < 19) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_job_op(c);
    owed_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // hold the sender off until every owed result is back
  task automatic drain_owed();
    @(negedge clk_i);
    start <= 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    dsjq_pkg::out_t want;
    if (rst_ni && result_valid_o) begin
      if (owed_results.size() == 0) begin
        flag_mismatch("result with nothing owed, status", 32'(result_o.status), 32'h0);
      end else begin
        want = owed_results.pop_front();
        if (result_o.status != want.status)
          flag_mismatch("status", 32'(result_o.status), 32'(want.status));
        if (result_o.head_handle != want.head_handle)
          flag_mismatch("head_handle", 32'(result_o.head_handle), 32'(want.head_handle));
        if (result_o.head_key != want.head_key)
          flag_mismatch("head_key", result_o.head_key, want.head_key);
        if (result_o.head_task != want.head_task)
          flag_mismatch("head_task", result_o.head_task, want.head_task);
        if (result_o.removed_count != want.removed_count)
          flag_mismatch("removed_count", 32'(result_o.removed_count),
                        32'(want.removed_count));
        if (result_o.occupancy != want.occupancy)
          flag_mismatch("occupancy", 32'(result_o.occupancy), 32'(want.occupancy));
      end
    end
  end

  // cycles since the last beat in either direction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) idle_run <= 0;
    else idle_run <= idle_run + 1;
  end

  // watchdog
  initial begin
    while (idle_run < STALL_LIMIT) @(posedge clk_i);
    $display("  no beat for %0d cycles, %0d results still owed", idle_run,
             owed_results.size());
    $display("deadline_sorted_job_queue: mismatch");
    $finish;
  end

  // stimulus
  initial begin
    mix_e mix;
    int   phase_len;
    int   phase_no;
    int   k;
    errors     = 0;
    items_sent = 0;
    idle_run   = 0;
    n_insert = 0; n_pop = 0; n_peek = 0; n_remove = 0;
    n_full = 0; n_empty = 0; n_purged = 0; peak_fill = 0;
    rst_ni = 1'b0;
    start  = 1'b0;
    cmd_i  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (k = 0; k < N_ROWS; k++)
      issue_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].want, 1'b1);

    // random phases; the first one fills the queue past full
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      if (phase_no == 0) mix = MIX_FILL;
      else begin
        case ($urandom_range(3))
          0:       mix = MIX_FILL;
          1:       mix = MIX_DRAIN;
          2:       mix = MIX_PURGE;
          default: mix = MIX_MIXED;
        endcase
      end
      phase_len = (mix == MIX_FILL) ? $urandom_range(90, 160) : $urandom_range(40, 140);
      for (k = 0; k < phase_len && items_sent < ITEM_TARGET; k++)
        // a long stretch in the middle runs with no sender gaps
        issue_cmd(random_job_cmd(mix), 1'b0, '0, !(items_sent >= 700 && items_sent < 1000));
      if (phase_no == 0 || $urandom_range(2) == 0) drain_owed();
      phase_no++;
    end

    // wind down
    @(negedge clk_i);
    start <= 1'b0;
    for (k = 0; k < STALL_LIMIT && owed_results.size() != 0; k++) @(posedge clk_i);
    repeat (QDEPTH + 8) @(posedge clk_i);
    if (owed_results.size() != 0)
      flag_mismatch("results never delivered", 32'(owed_results.size()), 32'h0);

    $display("  %0d commands: %0d insert (%0d full), %0d pop, %0d peek, %0d empty hits",
             items_sent, n_insert, n_full, n_pop, n_peek, n_empty);
    $display("  %0d removes purged %0d jobs; peak fill %0d of %0d; %0d errors",
             n_remove, n_purged, peak_fill, QDEPTH, errors);
    if (errors == 0) $display("deadline_sorted_job_queue: match");
    else $display("deadline_sorted_job_queue: mismatch");
    $finish;
  end

endmodule

>>> filelist.f
rtl/dsjq_pkg.sv
rtl/dsjq_dp.sv
rtl/dsjq_ctrl.sv
rtl/deadline_sorted_job_queue.sv
bench/deadline_sorted_job_queue_tb.sv
